### design/facache_pkg.sv
// shared constants, types and request structs of the fully associative cache
`default_nettype none

package facache_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned TAG_W = 64;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LINE_W = TAG_W + DATA_W;
  localparam int unsigned LFSR_W = 16;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned PROD_W = LFSR_W + RECIP_W;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LFSR_W-1:0] LFSR_TOGGLE = 16'hB400;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'h0001;
  localparam bit ENTRIES_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  // rounded-up reciprocal, exact quotient for any 16-bit lfsr value
  localparam logic [RECIP_W-1:0] VICTIM_RECIP =
    RECIP_W'((64'd1 << RECIP_W) / ENTRIES + 64'd1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic {
    REG_SEED = 1'b0,
    REG_NONE = 1'b1
  } reg_e;

  typedef struct packed {
    logic              load;
    logic [LFSR_W-1:0] seed;
    logic              start;
  } victim_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } victim_rsp_t;

endpackage

`default_nettype wire

### design/fully_assoc_cache_random_repl.sv
// top level of the fully associative byte cache with random replacement
`default_nettype none

// One request at a time. A read, write or flush walks the tag ram one entry
// per cycle through a single 64-bit tag comparator, then passes the drain
// and decide states; a line write adds the write state. A read or write miss
// with every line valid also steps the victim lfsr: the index is the low bits
// of the new value when ENTRIES is a power of two, else its reciprocal
// remainder. Opcode 3 skips the scan and goes straight to the done state. The
// result sits in an output register, so the next request may be taken while
// it waits; a request that finishes while an earlier result is still
// unaccepted holds until that one leaves. Valid bits clear at reset; no
// clearing pass is needed.
module fully_assoc_cache_random_repl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [facache_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [facache_pkg::PDATA_W-1:0]   pwdata,
  output logic      [facache_pkg::PDATA_W-1:0]   prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [facache_pkg::TAG_W-1:0]     address_i,
  input  wire logic [facache_pkg::DATA_W-1:0]    write_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [facache_pkg::DATA_W-1:0]    read_data_o,
  output logic                                   hit_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_VICTIM,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e                              state_q, state_d;
  facache_pkg::op_e                    op_q, op_d;
  logic [facache_pkg::TAG_W-1:0]       addr_q, addr_d;
  logic [facache_pkg::DATA_W-1:0]      wdata_q, wdata_d;
  logic [facache_pkg::IDX_W-1:0]       scan_idx_q, scan_idx_d;
  logic                                cmp_vld_q, cmp_vld_d;
  logic [facache_pkg::IDX_W-1:0]       cmp_idx_q, cmp_idx_d;
  logic                                hit_q, hit_d;
  logic [facache_pkg::IDX_W-1:0]       hit_idx_q, hit_idx_d;
  logic [facache_pkg::DATA_W-1:0]      hit_byte_q, hit_byte_d;
  logic                                free_q, free_d;
  logic [facache_pkg::IDX_W-1:0]       free_idx_q, free_idx_d;
  logic [facache_pkg::IDX_W-1:0]       wr_idx_q, wr_idx_d;
  logic [facache_pkg::DATA_W-1:0]      wr_byte_q, wr_byte_d;
  logic                                wr_clear_q, wr_clear_d;
  logic [facache_pkg::DATA_W-1:0]      res_data_q, res_data_d;
  logic                                res_hit_q, res_hit_d;
  logic [facache_pkg::ENTRIES-1:0]     valid_q, valid_d;
  logic [facache_pkg::LFSR_W-1:0]      seed_q, seed_d;
  logic                                out_valid_q, out_valid_d;
  logic [facache_pkg::DATA_W-1:0]      out_data_q, out_data_d;
  logic                                out_hit_q, out_hit_d;

  logic                                ram_re;
  logic                                ram_we;
  logic [facache_pkg::LINE_W-1:0]      ram_wdata;
  logic [facache_pkg::LINE_W-1:0]      ram_rdata;
  logic                                tag_match;
  logic                                cfg_we;
  logic                                in_accept;
  facache_pkg::victim_req_t            vreq;
  facache_pkg::victim_rsp_t            vrsp;

  facache_ram #(
    .WIDTH (facache_pkg::LINE_W),
    .DEPTH (facache_pkg::ENTRIES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  facache_victim u_victim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (vreq),
    .rsp_o  (vrsp)
  );

  assign pready = 1'b1;
  assign prdata = facache_pkg::PDATA_W'(seed_q);
  assign cfg_we = psel && penable && pwrite
                  && (facache_pkg::reg_e'(paddr[2]) == facache_pkg::REG_SEED);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign hit_o       = out_hit_q;

  assign tag_match = cmp_vld_q && valid_q[cmp_idx_q]
                     && (ram_rdata[facache_pkg::LINE_W-1:facache_pkg::DATA_W] == addr_q);
  assign ram_re    = (state_q == ST_SCAN);
  assign ram_we    = (state_q == ST_WRITE);
  assign ram_wdata = wr_clear_q ? '0 : {addr_q, wr_byte_q};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    wdata_d     = wdata_q;
    scan_idx_d  = scan_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_byte_d  = hit_byte_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    wr_idx_d    = wr_idx_q;
    wr_byte_d   = wr_byte_q;
    wr_clear_d  = wr_clear_q;
    res_data_d  = res_data_q;
    res_hit_d   = res_hit_q;
    valid_d     = valid_q;
    seed_d      = seed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_hit_d   = out_hit_q;
    vreq.load   = cfg_we;
    vreq.seed   = pwdata[facache_pkg::LFSR_W-1:0];
    vreq.start  = 1'b0;

    if (cfg_we) begin
      seed_d = pwdata[facache_pkg::LFSR_W-1:0];
    end

    // compare stage works on the ram data read in the previous cycle
    if (tag_match && !hit_q) begin
      hit_d      = 1'b1;
      hit_idx_d  = cmp_idx_q;
      hit_byte_d = ram_rdata[facache_pkg::DATA_W-1:0];
    end
    if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
      free_d     = 1'b1;
      free_idx_d = cmp_idx_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d       = facache_pkg::op_e'(opcode_i);
          addr_d     = address_i;
          wdata_d    = write_data_i;
          scan_idx_d = '0;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          res_data_d = '0;
          res_hit_d  = 1'b0;
          if (facache_pkg::op_e'(opcode_i) == facache_pkg::OP_NOP) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_idx_q;
        if (scan_idx_q == facache_pkg::LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_hit_d  = hit_q;
        wr_clear_d = 1'b0;
        wr_byte_d  = '0;
        state_d    = ST_DONE;
        case (op_q)
          facache_pkg::OP_READ: begin
            if (hit_q) begin
              res_data_d = hit_byte_q;
            end
          end
          facache_pkg::OP_WRITE: begin
            wr_byte_d = wdata_q;
            if (hit_q) begin
              wr_idx_d = hit_idx_q;
              state_d  = ST_WRITE;
            end
          end
          facache_pkg::OP_FLUSH: begin
            if (hit_q) begin
              wr_idx_d   = hit_idx_q;
              wr_clear_d = 1'b1;
              state_d    = ST_WRITE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
        // line fill on a read or write miss
        if (!hit_q && (op_q == facache_pkg::OP_READ || op_q == facache_pkg::OP_WRITE)) begin
          if (free_q) begin
            wr_idx_d = free_idx_q;
            state_d  = ST_WRITE;
          end else begin
            vreq.start = 1'b1;
            state_d    = ST_VICTIM;
          end
        end
      end
      ST_VICTIM: begin
        if (vrsp.done) begin
          wr_idx_d = vrsp.idx;
          state_d  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        valid_d[wr_idx_q] = !wr_clear_q;
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_data_q;
          out_hit_d   = res_hit_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      seed_q      <= facache_pkg::SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      valid_q     <= valid_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    wdata_q    <= wdata_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_byte_q <= hit_byte_d;
    free_idx_q <= free_idx_d;
    wr_idx_q   <= wr_idx_d;
    wr_byte_q  <= wr_byte_d;
    wr_clear_q <= wr_clear_d;
    res_data_q <= res_data_d;
    res_hit_q  <= res_hit_d;
    out_data_q <= out_data_d;
    out_hit_q  <= out_hit_d;
  end

`ifndef ASSERT_OFF
  a_hit_line_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && hit_q) |-> valid_q[hit_idx_q])
    else $error("hit recorded on an invalid line");

  a_free_line_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && free_q) |-> !valid_q[free_idx_q])
    else $error("free slot points at a valid line");

  a_no_free_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && !free_q) |-> (&valid_q))
    else $error("scan missed an invalid line");

  a_data_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_data_o != '0) |-> hit_o)
    else $error("nonzero read data without a hit");

  a_victim_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vrsp.done |-> (state_q == ST_VICTIM))
    else $error("victim result outside victim wait");
`endif

endmodule

`default_nettype wire

### design/facache_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module facache_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/facache_victim.sv
// victim picker: galois lfsr and a reciprocal remainder unit
`default_nettype none

module facache_victim (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire facache_pkg::victim_req_t req_i,
  output facache_pkg::victim_rsp_t      rsp_o
);

  logic [facache_pkg::LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [facache_pkg::LFSR_W-1:0] lfsr_next;
  logic [facache_pkg::LFSR_W-1:0] val_q, val_d;
  logic [facache_pkg::LFSR_W-1:0] quot_q, quot_d;
  logic                           phase_q, phase_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [facache_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [facache_pkg::PROD_W-1:0] prod;
  logic [facache_pkg::LFSR_W-1:0] rem;

  assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? facache_pkg::LFSR_TOGGLE : '0);
  assign prod = facache_pkg::PROD_W'(val_q) * facache_pkg::PROD_W'(facache_pkg::VICTIM_RECIP);
  assign rem  = val_q - quot_q * facache_pkg::LFSR_W'(facache_pkg::ENTRIES);

  always_comb begin
    lfsr_d  = lfsr_q;
    val_d   = val_q;
    quot_d  = quot_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    idx_d   = idx_q;
    if (req_i.load) begin
      lfsr_d = (req_i.seed == '0) ? facache_pkg::SEED_RESET : req_i.seed;
    end else if (req_i.start) begin
      lfsr_d  = lfsr_next;
      val_d   = lfsr_next;
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (facache_pkg::ENTRIES_POW2) begin
        idx_d  = val_q[facache_pkg::IDX_W-1:0];
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!phase_q) begin
        quot_d  = prod[facache_pkg::PROD_W-1:facache_pkg::RECIP_W];
        phase_d = 1'b1;
      end else begin
        idx_d   = rem[facache_pkg::IDX_W-1:0];
        phase_d = 1'b0;
        busy_d  = 1'b0;
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q  <= facache_pkg::SEED_RESET;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      lfsr_q  <= lfsr_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    quot_q <= quot_d;
    idx_q  <= idx_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.idx  = idx_q;

endmodule

`default_nettype wire
